### rtl/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Opcodes, item record and saturation helpers for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_CMP      = 4'd4,
        CMD_MIN      = 4'd5,
        CMD_MAX      = 4'd6,
        CMD_INC      = 4'd7,
        CMD_DEC      = 4'd8,
        CMD_TO_INT   = 4'd9,
        CMD_FROM_INT = 4'd10
    } t_cmd;

    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        res;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               ovf;
        logic               dz;
    } t_item;

    // 33-bit signed sum to 32 bits: {ovf, value}
    function automatic logic [32:0] sat_sum(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return {1'b1, (s[32] ? W_MIN : W_MAX)};
        end
        return {1'b0, s[31:0]};
    endfunction

    // magnitude plus sign to 32 bits: {ovf, value}
    function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000) begin
                return {1'b1, W_MIN};
            end
            return {1'b0, 32'(64'd0 - m)};
        end
        if (m > 64'h0000_0000_7FFF_FFFF) begin
            return {1'b1, W_MAX};
        end
        return {1'b0, m[31:0]};
    endfunction

endpackage

### rtl/fxalu_if.sv
// ----------------------------------------------------------------------------
// fxalu_if
// Valid/ready channels for ALU commands and results.
// ----------------------------------------------------------------------------
interface fxalu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         cmd;
    logic signed [31:0] a_raw;
    logic signed [31:0] b_raw;

    modport source (output valid, cmd, a_raw, b_raw, input ready);
    modport sink   (input valid, cmd, a_raw, b_raw, output ready);
endinterface

interface fxalu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               greater;
    logic               less;
    logic               equal;
    logic               overflow;
    logic               div_by_zero;

    modport source (output valid, result, greater, less, equal, overflow, div_by_zero,
                    input ready);
    modport sink   (input valid, result, greater, less, equal, overflow, div_by_zero,
                    output ready);
endinterface

### rtl/fixed_point_q24_8_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Signed fixed-point ALU with saturation, exact rounded multiply and divide.
// ----------------------------------------------------------------------------
// Accepts one command per cycle while the input queue has room and returns
// one result per command, in order. Every command takes the same path: the
// queue, the multiplier register, 32 + FRAC_BITS divider stages of one
// quotient bit each, then the output register. Back pressure on the result
// channel stalls the pipeline as a whole; the two-entry queue in front keeps
// taking commands until it fills.
module fixed_point_q24_8_alu_unit #(
    parameter int FRAC_BITS = 8
) (
    input logic         i_clk,
    input logic         i_rst_n,
    fxalu_in_if.sink    i_in,
    fxalu_out_if.source o_out
);
    import fxalu_pkg::*;

    t_item w_front;
    t_item w_q_item;
    t_item w_res;
    logic  w_full;
    logic  w_empty;
    logic  w_take;
    logic  w_res_valid;

    fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_cmd  (i_in.cmd),
        .i_a    (i_in.a_raw),
        .i_b    (i_in.b_raw),
        .o_item (w_front)
    );

    fxalu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_in.valid),
        .i_wdata (w_front),
        .o_full  (w_full),
        .i_rd    (w_take),
        .o_rdata (w_q_item),
        .o_empty (w_empty)
    );

    fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_item  (w_q_item),
        .o_take  (w_take),
        .i_ready (o_out.ready),
        .o_valid (w_res_valid),
        .o_item  (w_res)
    );

    assign i_in.ready        = !w_full;
    assign o_out.valid       = w_res_valid;
    assign o_out.result      = w_res.res;
    assign o_out.greater     = w_res.gt;
    assign o_out.less        = w_res.lt;
    assign o_out.equal       = w_res.eq;
    assign o_out.overflow    = w_res.ovf;
    assign o_out.div_by_zero = w_res.dz;

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot({o_out.greater, o_out.less, o_out.equal}))
        else $error("comparison flags not one-hot");

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.div_by_zero |-> !o_out.overflow)
        else $error("divide by zero with overflow");

    a_dz_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.div_by_zero |->
            (o_out.result == W_MAX) || (o_out.result == W_MIN))
        else $error("divide by zero result not saturated");

endmodule

### rtl/fxalu_front.sv
// ----------------------------------------------------------------------------
// fxalu_front
// Decodes a command, computes flags and all results but multiply and divide.
// ----------------------------------------------------------------------------
module fxalu_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic [3:0]         i_cmd,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output fxalu_pkg::t_item   o_item
);
    import fxalu_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    logic [32:0]   w_add;
    logic [32:0]   w_sub;
    logic [32:0]   w_inc;
    logic [32:0]   w_dec;
    logic [DW-1:0] w_fi;
    logic          w_fi_ok;
    logic [32:0]   w_sat;

    assign w_add   = {i_a[31], i_a} + {i_b[31], i_b};
    assign w_sub   = {i_a[31], i_a} - {i_b[31], i_b};
    assign w_inc   = {i_a[31], i_a} + 33'd1;
    assign w_dec   = {i_a[31], i_a} - 33'd1;
    assign w_fi    = {i_a, {FRAC_BITS{1'b0}}};
    assign w_fi_ok = (i_a[31:31-FRAC_BITS] == {(FRAC_BITS+1){i_a[31]}});

    always_comb begin
        o_item     = '0;
        o_item.cmd = i_cmd;
        o_item.a   = i_a;
        o_item.b   = i_b;
        o_item.gt  = (i_a > i_b);
        o_item.lt  = (i_a < i_b);
        o_item.eq  = (i_a == i_b);
        w_sat      = '0;
        case (i_cmd)
            CMD_ADD: begin
                w_sat = sat_sum(w_add);
            end
            CMD_SUB: begin
                w_sat = sat_sum(w_sub);
            end
            CMD_INC: begin
                w_sat = sat_sum(w_inc);
            end
            CMD_DEC: begin
                w_sat = sat_sum(w_dec);
            end
            CMD_MIN: begin
                w_sat = {1'b0, ((i_a > i_b) ? i_b : i_a)};
            end
            CMD_MAX: begin
                w_sat = {1'b0, ((i_a < i_b) ? i_b : i_a)};
            end
            CMD_TO_INT: begin
                w_sat = {1'b0, 32'(i_a >>> FRAC_BITS)};
            end
            CMD_FROM_INT: begin
                if (w_fi_ok) begin
                    w_sat = {1'b0, w_fi[31:0]};
                end else begin
                    w_sat = {1'b1, (i_a[31] ? W_MIN : W_MAX)};
                end
            end
            CMD_DIV: begin
                if (i_b == 32'sd0) begin
                    o_item.dz = 1'b1;
                    w_sat     = {1'b0, (i_a[31] ? W_MIN : W_MAX)};
                end
            end
            default: begin
                w_sat = '0;
            end
        endcase
        o_item.ovf = w_sat[32];
        o_item.res = w_sat[31:0];
    end

endmodule

### rtl/fxalu_fifo.sv
// ----------------------------------------------------------------------------
// fxalu_fifo
// Two-entry queue between the decode front and the arithmetic back end.
// ----------------------------------------------------------------------------
module fxalu_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fxalu_pkg::t_item i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output fxalu_pkg::t_item o_rdata,
    output logic             o_empty
);
    import fxalu_pkg::*;

    t_item       r_mem [0:1];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        n_wp;
    logic        n_rp;
    logic [1:0]  n_cnt;
    logic        w_wr;
    logic        w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = w_wr ? ~r_wp : r_wp;
        n_rp  = w_rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

### rtl/fxalu_back.sv
// ----------------------------------------------------------------------------
// fxalu_back
// Multiplier and one-bit-per-stage divider pipeline with rounding and
// saturation, followed by the output register.
// ----------------------------------------------------------------------------
module fxalu_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fxalu_pkg::t_item i_item,
    output logic             o_take,
    input  logic             i_ready,
    output logic             o_valid,
    output fxalu_pkg::t_item o_item
);
    import fxalu_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic          valid;
        t_item         item;
        logic          neg;
        logic [31:0]   den;
        logic [DW-1:0] num;
        logic [31:0]   rem;
        logic [DW-1:0] quo;
        logic [63:0]   prod;
    } t_stage;

    t_stage      r_st [0:DW];
    t_stage      n_st [0:DW];
    logic        r_out_valid;
    t_item       r_out;
    t_item       n_out;
    logic        w_en;
    logic [31:0] w_mag_a;
    logic [31:0] w_mag_b;
    logic [63:0] w_prod;
    logic [63:0] w_mq;
    logic        w_rnd;
    logic [DW:0] w_dq;
    logic [32:0] w_sat;

    assign w_en    = !r_out_valid || i_ready;
    assign o_take  = w_en && i_valid;
    assign w_mag_a = i_item.a[31] ? 32'(-i_item.a) : 32'(i_item.a);
    assign w_mag_b = i_item.b[31] ? 32'(-i_item.b) : 32'(i_item.b);
    assign w_prod  = w_mag_a * w_mag_b;

    always_comb begin
        n_st[0].valid = i_valid;
        n_st[0].item  = i_item;
        n_st[0].neg   = i_item.a[31] ^ i_item.b[31];
        n_st[0].den   = w_mag_b;
        n_st[0].num   = {w_mag_a, {FRAC_BITS{1'b0}}};
        n_st[0].rem   = '0;
        n_st[0].quo   = '0;
        n_st[0].prod  = w_prod;
    end

    for (genvar k = 1; k <= DW; k++) begin : g_div
        logic [32:0] w_part;
        logic        w_ge;
        assign w_part = {r_st[k-1].rem, r_st[k-1].num[DW-1]};
        assign w_ge   = (w_part >= {1'b0, r_st[k-1].den});
        always_comb begin
            n_st[k]     = r_st[k-1];
            n_st[k].num = {r_st[k-1].num[DW-2:0], 1'b0};
            n_st[k].rem = w_ge ? 32'(w_part - {1'b0, r_st[k-1].den}) : w_part[31:0];
            n_st[k].quo = {r_st[k-1].quo[DW-2:0], w_ge};
        end
    end

    assign w_mq  = (r_st[DW].prod + HALF) >> FRAC_BITS;
    assign w_rnd = ({r_st[DW].rem, 1'b0} >= {1'b0, r_st[DW].den});
    assign w_dq  = {1'b0, r_st[DW].quo} + {{DW{1'b0}}, w_rnd};

    always_comb begin
        n_out = r_st[DW].item;
        w_sat = '0;
        case (r_st[DW].item.cmd)
            CMD_MUL: begin
                w_sat     = sat_mag(w_mq, r_st[DW].neg);
                n_out.res = w_sat[31:0];
                n_out.ovf = w_sat[32];
            end
            CMD_DIV: begin
                if (!r_st[DW].item.dz) begin
                    w_sat     = sat_mag(64'(w_dq), r_st[DW].neg);
                    n_out.res = w_sat[31:0];
                    n_out.ovf = w_sat[32];
                end
            end
            default: begin
                w_sat = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_st[k].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k <= DW; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out_valid <= r_st[DW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Q24.8 fixed-point ALU: a directed table of
// corner-case operations, then random traffic with random gaps on both
// channels and one long result stall, each result checked against the
// table's expected values where it gives them, else an in-bench arithmetic predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fxalu_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 36;
    localparam int N_RANDOM = 430;
    localparam longint LIMIT = 200000;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
        bit          known;
        t_item       res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    fxalu_in_if  in_ch ();
    fxalu_out_if out_ch ();

    fixed_point_q24_8_alu_unit #(.FRAC_BITS(FRAC)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_item  pending_results[$];
    t_row   rows[$];
    int     errors = 0;
    longint cycles = 0;
    bit     stim_done = 0;
    bit     hold_off = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint clamp_w(longint v, ref bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_item alu_predict(logic [3:0] cmd, logic [31:0] ar, logic [31:0] br);
        t_item  o;
        longint a, b, r, ma, mb;
        longint unsigned p, q, num, den;
        bit     ovf, dz, neg;
        a = longint'(signed'(ar));
        b = longint'(signed'(br));
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        neg = (a < 0) != (b < 0);
        ovf = 0;
        dz = 0;
        r = 0;
        case (cmd)
            CMD_ADD: r = clamp_w(a + b, ovf);
            CMD_SUB: r = clamp_w(a - b, ovf);
            CMD_MUL, CMD_DIV: begin
                if (cmd == CMD_MUL) begin
                    p = ma * mb;
                    q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
                end else if (b == 0) begin
                    dz = 1;
                    q = 0;
                end else begin
                    num = ma << FRAC;
                    den = mb;
                    q = (2 * num + den) / (2 * den);
                end
                if (dz) begin
                    r = a < 0 ? -64'sd2147483648 : 64'sd2147483647;
                end else begin
                    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
                    r = clamp_w(neg ? -longint'(q) : longint'(q), ovf);
                end
            end
            CMD_CMP: r = 0;
            CMD_MIN: r = a > b ? b : a;
            CMD_MAX: r = a < b ? b : a;
            CMD_INC: r = clamp_w(a + 1, ovf);
            CMD_DEC: r = clamp_w(a - 1, ovf);
            CMD_TO_INT: r = a >>> FRAC;
            CMD_FROM_INT: r = clamp_w(a * (64'sd1 << FRAC), ovf);
            default: r = 0;
        endcase
        o = '0;
        o.cmd = cmd;
        o.a = ar;
        o.b = br;
        o.res = r[31:0];
        o.gt = a > b;
        o.lt = a < b;
        o.eq = a == b;
        o.ovf = ovf;
        o.dz = dz;
        return o;
    endfunction

    function automatic t_item known_res(logic [31:0] res, bit gt, bit lt, bit eq,
                                        bit ovf, bit dz);
        t_item o;
        o = '0;
        o.res = res;
        o.gt = gt;
        o.lt = lt;
        o.eq = eq;
        o.ovf = ovf;
        o.dz = dz;
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return W_MAX - $urandom_range(0, 3);
            1: return W_MIN + $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 4096)) - 32'd2048;
            3: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
                           bit known, t_item res);
        t_row r;
        r.cmd = cmd;
        r.a = a;
        r.b = b;
        r.known = known;
        r.res = res;
        rows.push_back(r);
    endtask

    task automatic send_op(t_row r);
        t_item e;
        int    gap;
        e = alu_predict(r.cmd, r.a, r.b);
        if (r.known) begin
            e.res = r.res.res;
            e.gt = r.res.gt;
            e.lt = r.res.lt;
            e.eq = r.res.eq;
            e.ovf = r.res.ovf;
            e.dz = r.res.dz;
        end
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd <= r.cmd;
        in_ch.a_raw <= r.a;
        in_ch.b_raw <= r.b;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(e);
    endtask

    // directed table
    initial begin
        t_item z;
        z = '0;
        add_row(CMD_ADD, W_MAX, 32'd1, 1, known_res(W_MAX, 1, 0, 0, 1, 0));
        add_row(CMD_ADD, W_MIN, W_MIN, 1, known_res(W_MIN, 0, 0, 1, 1, 0));
        add_row(CMD_SUB, W_MIN, 32'd1, 1, known_res(W_MIN, 0, 1, 0, 1, 0));
        add_row(CMD_SUB, W_MAX, 32'hFFFF_FFFF, 1, known_res(W_MAX, 1, 0, 0, 1, 0));
        add_row(CMD_MUL, 32'h0000_0180, 32'h0000_0200, 0, z);
        add_row(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 0, z);
        add_row(CMD_MUL, W_MIN, W_MIN, 0, z);
        add_row(CMD_MUL, W_MAX, 32'hFFFF_FF00, 0, z);
        add_row(CMD_DIV, 32'h0000_0100, 32'd0, 1, known_res(W_MAX, 1, 0, 0, 0, 1));
        add_row(CMD_DIV, 32'hFFFF_FF00, 32'd0, 1, known_res(W_MIN, 0, 1, 0, 0, 1));
        add_row(CMD_DIV, 32'd0, 32'd0, 1, known_res(W_MAX, 0, 0, 1, 0, 1));
        add_row(CMD_DIV, W_MIN, 32'd1, 0, z);
        add_row(CMD_DIV, 32'h0000_0100, 32'h0000_0300, 0, z);
        add_row(CMD_DIV, W_MIN, 32'hFFFF_FFFF, 0, z);
        add_row(CMD_CMP, 32'd5, 32'd5, 1, known_res(32'd0, 0, 0, 1, 0, 0));
        add_row(CMD_MIN, W_MIN, W_MAX, 1, known_res(W_MIN, 0, 1, 0, 0, 0));
        add_row(CMD_MAX, W_MIN, W_MAX, 1, known_res(W_MAX, 0, 1, 0, 0, 0));
        add_row(CMD_INC, W_MAX, 32'd0, 1, known_res(W_MAX, 1, 0, 0, 1, 0));
        add_row(CMD_DEC, W_MIN, 32'd0, 1, known_res(W_MIN, 0, 1, 0, 1, 0));
        add_row(CMD_TO_INT, 32'hFFFF_FF01, 32'd0, 1,
                known_res(32'hFFFF_FFFF, 0, 1, 0, 0, 0));
        add_row(CMD_TO_INT, W_MAX, W_MAX, 1, known_res(32'h007F_FFFF, 0, 0, 1, 0, 0));
        add_row(CMD_FROM_INT, 32'h0080_0000, 32'd0, 1, known_res(W_MAX, 1, 0, 0, 1, 0));
        add_row(CMD_FROM_INT, 32'hFF80_0000, 32'd0, 1,
                known_res(W_MIN, 0, 1, 0, 0, 0));
        add_row(4'd11, 32'd1, 32'd2, 1, known_res(32'd0, 0, 1, 0, 0, 0));
        add_row(4'd15, 32'hFFFF_FFFF, 32'd0, 1, known_res(32'd0, 0, 1, 0, 0, 0));
    end

    // sender
    initial begin
        t_row r;
        in_ch.valid <= 0;
        in_ch.cmd <= '0;
        in_ch.a_raw <= '0;
        in_ch.b_raw <= '0;
        i_rst_n <= 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (rows[i]) send_op(rows[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            r.cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
            r.a = rand_operand();
            r.b = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
            if ($urandom_range(0, 7) == 0) r.b = r.a;
            r.known = 0;
            send_op(r);
        end
        in_ch.valid <= 0;
        stim_done = 1;
    end

    // long result stall while the sender keeps going
    initial begin
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off = 1;
        repeat (300) @(posedge i_clk);
        hold_off = 0;
    end

    // receiver
    initial begin
        int gap;
        out_ch.ready <= 0;
        wait (i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0 || hold_off) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_item e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: result=%h", out_ch.result);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (out_ch.result !== e.res) begin
                    $error("result: cmd=%0d a=%h b=%h expected %h actual %h",
                           e.cmd, e.a, e.b, e.res, out_ch.result);
                    errors++;
                end
                if (out_ch.greater !== e.gt) begin
                    $error("greater: expected %b actual %b", e.gt, out_ch.greater);
                    errors++;
                end
                if (out_ch.less !== e.lt) begin
                    $error("less: expected %b actual %b", e.lt, out_ch.less);
                    errors++;
                end
                if (out_ch.equal !== e.eq) begin
                    $error("equal: expected %b actual %b", e.eq, out_ch.equal);
                    errors++;
                end
                if (out_ch.overflow !== e.ovf) begin
                    $error("overflow: cmd=%0d a=%h b=%h expected %b actual %b",
                           e.cmd, e.a, e.b, e.ovf, out_ch.overflow);
                    errors++;
                end
                if (out_ch.div_by_zero !== e.dz) begin
                    $error("div_by_zero: expected %b actual %b", e.dz, out_ch.div_by_zero);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### sim.f
rtl/fxalu_pkg.sv
rtl/fxalu_if.sv
rtl/fxalu_front.sv
rtl/fxalu_fifo.sv
rtl/fxalu_back.sv
rtl/fixed_point_q24_8_alu_unit.sv
tb/testbench.sv
